@@ src/ucp_pkg.sv @@
// Shared types, character codes and decode helpers for the code point line parser.
// Used by unicode_codepoint_line_parser_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ucp_pkg;

   localparam int MAX_CODES = 128;
   localparam int DIGITS_MAX = 5;
   localparam logic [7:0] LIMIT_RESET = 8'd128;

   localparam logic [7:0] CHAR_NL = 8'h0A;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_U_UP = 8'h55;
   localparam logic [7:0] CHAR_U_LO = 8'h75;

   typedef enum logic [2:0] {
      PH_LEAD = 3'd0,
      PH_LEAD_CMT = 3'd1,
      PH_GAP = 3'd2,
      PH_GAP_CMT = 3'd3,
      PH_PLUS = 3'd4,
      PH_DIGITS = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_LINE = 2'd1,
      EV_ERROR = 2'd2,
      EV_END = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic end_of_input;
   } req_item_type;

   typedef struct packed {
      logic code_valid;
      logic [19:0] code_point;
      event_type event_res;
      logic [7:0] line_count;
   } rsp_item_type;

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_ws(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

   // bit 4: valid hex digit, bits 3:0: its value
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] res;
      res = '0;
      case (b) inside
         [8'h30:8'h39]: res = {1'b1, b[3:0]};
         [8'h41:8'h46], [8'h61:8'h66]: res = {1'b1, b[3:0] + 4'd9};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ src/unicode_codepoint_line_parser_top.sv @@
// Top level of the code point line parser: input register, parse logic, result register.
// Depends on ucp_pkg for item types, phase and event codes and character decode.
//
// Usage:
//   req_valid/req_stall/req_data carry one text byte or an end-of-input mark
//   per beat. rsp_valid/rsp_stall/rsp_data carry at most one result per input
//   beat: a completed code point, a line/error/end event, or both together
//   when a newline ends a token. Beats that produce nothing give no result.
//   csr_wr_en/csr_wr_data set the per-line token limit (capped at 128);
//   write it only while the block is idle.
// Path: a beat is held in the input register, then its result in the result
//   register, which drives rsp.
// Throughput: one beat per cycle except while a result waits on rsp_stall
//   (see Stall), set by the single parse step between the input register and the result register.
// Reset: synchronous; parser returns to the leading-skip phase with an empty
//   line, the limit returns to 128 and both registers are emptied.
// Stall: while rsp_stall holds a result, the block still takes beats that
//   produce no result; a beat that would produce one waits in the input
//   register and req_stall rises until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module unicode_codepoint_line_parser_top import ucp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_item_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_item_type rsp_data,
   input wire logic csr_wr_en,
   input wire logic [7:0] csr_wr_data
);

   localparam logic [7:0] LIMIT_CAP = 8'(MAX_CODES);
   localparam logic [2:0] DIGITS_LAST = 3'(DIGITS_MAX);

   logic [7:0] limit_ff;
   logic s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;

   phase_type phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [19:0] acc_ff, acc_in;
   logic [2:0] digits_ff, digits_in;

   logic [7:0] limit;
   logic [7:0] b;
   logic eoi;
   logic [4:0] hex;
   logic [2:0] digits_inc;
   logic start_ok;
   event_type start_ev;
   event_type ev;
   logic emit;
   logic [19:0] cp;
   logic [7:0] line_cnt;
   logic has_result;
   logic s1_adv;
   logic req_take;

   assign limit = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign b = s1_item_ff.byte_in;
   assign eoi = s1_item_ff.end_of_input;
   assign hex = hex_decode(b);
   assign digits_inc = digits_ff + 3'd1;
   assign start_ok = (count_ff < limit) && (b == CHAR_U_UP || b == CHAR_U_LO);
   assign start_ev = start_ok ? EV_NONE : EV_ERROR;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      digits_in = digits_ff;
      ev = EV_NONE;
      emit = 1'b0;
      cp = '0;
      line_cnt = '0;
      case (phase_ff)
         PH_LEAD_CMT: begin
            if (eoi) ev = EV_END;
            else if (b == CHAR_NL) ev = EV_LINE;
         end
         PH_GAP, PH_GAP_CMT: begin
            if (eoi) ev = (count_ff != 8'd0) ? EV_LINE : EV_END;
            else if (b == CHAR_NL) ev = EV_LINE;
            else if (phase_ff == PH_GAP_CMT) ev = EV_NONE;
            else if (b == CHAR_HASH) phase_in = PH_GAP_CMT;
            else if (!is_ws(b)) begin
               ev = start_ev;
               phase_in = PH_PLUS;
            end
         end
         PH_PLUS: begin
            if (eoi || b != CHAR_PLUS) ev = EV_ERROR;
            else begin
               phase_in = PH_DIGITS;
               acc_in = '0;
               digits_in = '0;
            end
         end
         PH_DIGITS: begin
            if (eoi) ev = EV_ERROR;
            else if (is_ws(b)) begin
               emit = 1'b1;
               cp = acc_ff;
               count_in = count_ff + 8'd1;
               phase_in = PH_GAP;
               if (b == CHAR_NL) ev = EV_LINE;
            end else if (!hex[4]) ev = EV_ERROR;
            else begin
               acc_in = {acc_ff[15:0], hex[3:0]};
               digits_in = digits_inc;
               // token closes on its last allowed digit
               if (digits_inc >= DIGITS_LAST) begin
                  emit = 1'b1;
                  cp = {acc_ff[15:0], hex[3:0]};
                  count_in = count_ff + 8'd1;
                  phase_in = PH_GAP;
               end
            end
         end
         default: begin
            phase_in = PH_LEAD;
            if (eoi) ev = EV_END;
            else if (b == CHAR_HASH) phase_in = PH_LEAD_CMT;
            else if (!is_ws(b)) begin
               ev = start_ev;
               phase_in = PH_PLUS;
            end
         end
      endcase
      if (ev == EV_LINE) line_cnt = count_in;
      // any report restarts the line
      if (ev != EV_NONE) begin
         phase_in = PH_LEAD;
         count_in = '0;
         acc_in = '0;
         digits_in = '0;
      end
   end

   assign has_result = emit || (ev != EV_NONE);
   assign s1_adv = s1_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_adv && has_result) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_LEAD;
         count_ff <= '0;
         acc_ff <= '0;
         digits_ff <= '0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance parse state only when the held beat is consumed
         if (s1_adv) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            acc_ff <= acc_in;
            digits_ff <= digits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_item_ff <= req_data;
      if (s1_adv && has_result) begin
         rsp_data_ff.code_valid <= emit;
         rsp_data_ff.code_point <= cp;
         rsp_data_ff.event_res <= ev;
         rsp_data_ff.line_count <= line_cnt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.code_valid || rsp_data_ff.event_res != EV_NONE))
      else $error("empty result in output register");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LIMIT_CAP)
      else $error("token count beyond cap");

   a_lead_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEAD || phase_ff == PH_LEAD_CMT) |-> (count_ff == 8'd0))
      else $error("leading phase with tokens on line");

   a_stall_holds_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && has_result && rsp_valid_ff))
      else $error("input stalled without a blocked result");

   a_line_count_only_on_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.event_res != EV_LINE) |-> (rsp_data_ff.line_count == 8'd0))
      else $error("line count on non-line result");

endmodule

`default_nettype wire
